/* design/cnm_pkg.sv */
// Shared types, constants and calendar helpers for the cron next-match search.
`timescale 1ns / 1ps

package cnm_pkg;

  // Configuration port geometry
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 60;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_MONTH   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DAY     = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_WEEKDAY = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_HOUR    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MINUTE  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_SECOND  = 3'd5;

  // Mask reset values
  localparam logic [11:0] MONTH_ALL   = 12'hFFF;
  localparam logic [30:0] DAY_ALL     = 31'h7FFF_FFFF;
  localparam logic [6:0]  WEEKDAY_ALL = 7'h7F;
  localparam logic [23:0] HOUR_ALL    = 24'hFF_FFFF;
  localparam logic [59:0] MINSEC_ALL  = 60'h0FFF_FFFF_FFFF_FFFF;

  // Last year the search may land in
  localparam logic [14:0] YEAR_LIMIT = 15'd16383;

  // Reciprocals: x / 100 = (x * K100) >> 21 for x < 2^15,
  // x / 7 = (x * K7) >> 18 for x < 2^15
  localparam logic [15:0] K100 = 16'd20972;
  localparam logic [15:0] K7   = 16'd37450;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
  } in_payload_t;

  typedef struct packed {
    logic        found;
    logic [13:0] match_year;
    logic [3:0]  match_month;
    logic [4:0]  match_day;
    logic [4:0]  match_hour;
    logic [5:0]  match_minute;
    logic [5:0]  match_second;
  } out_payload_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QY,
    S_QYY,
    S_SUM,
    S_Q7,
    S_WD,
    S_RUN,
    S_DONE
  } state_t;

  // Leap test from year mod 4 bits, year mod 100 and (year / 100) mod 4
  function automatic logic is_leap(input logic [1:0] y4, input logic [6:0] c100,
                                   input logic [1:0] c4h);
    logic r;
    begin
      r = ((y4 == 2'd0) && (c100 != 7'd0)) || ((c100 == 7'd0) && (c4h == 2'd0));
      return r;
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] r;
    begin
      unique case (mo)
        4'd2:                      r = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
        default:                   r = 5'd31;
      endcase
      return r;
    end
  endfunction

  // Month offset of the weekday formula
  function automatic logic [2:0] wk_offset(input logic [3:0] mo);
    logic [2:0] r;
    begin
      unique case (mo)
        4'd2:          r = 3'd3;
        4'd3:          r = 3'd2;
        4'd4:          r = 3'd5;
        4'd6:          r = 3'd3;
        4'd7:          r = 3'd5;
        4'd8:          r = 3'd1;
        4'd9:          r = 3'd4;
        4'd10:         r = 3'd6;
        4'd11:         r = 3'd2;
        4'd12:         r = 3'd4;
        default:       r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // Remainder by 7 of a value below 42
  function automatic logic [2:0] mod7_small(input logic [5:0] v);
    logic [5:0] r;
    begin
      priority if (v >= 6'd35) r = v - 6'd35;
      else if (v >= 6'd28)     r = v - 6'd28;
      else if (v >= 6'd21)     r = v - 6'd21;
      else if (v >= 6'd14)     r = v - 6'd14;
      else if (v >= 6'd7)      r = v - 6'd7;
      else                     r = v;
      return r[2:0];
    end
  endfunction

endpackage

/* design/cnm_if.sv */
// Valid/ready channel interfaces for the start time and the match result.
`timescale 1ns / 1ps

interface cnm_in_if;
  import cnm_pkg::*;
  logic        valid;
  logic        ready;
  in_payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cnm_out_if;
  import cnm_pkg::*;
  logic         valid;
  logic         ready;
  out_payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/cron_next_match_search.sv */
// Top level: cron schedule next-match search with seconds resolution.
// Setup runs through S_QY, S_QYY, S_SUM, S_Q7 and S_WD (shared multiplier derives leap
// counters and weekday), then one search step per cycle until a match, a year overflow or
// the step limit of MAX_STEPS - 1 steps, then the result goes into the output register.
// One start time at a time; each takes longer while the previous result waits to be taken.
// Reset: all six masks go to all ones, the sequencer idles and no result is valid.
`timescale 1ns / 1ps

module cron_next_match_search #(
  parameter int MAX_STEPS = 65535
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [cnm_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cnm_pkg::CFG_DW-1:0] cfg_wdata,
  cnm_in_if.sink                     in_ch,
  cnm_out_if.source                  out_ch
);
  import cnm_pkg::*;

  localparam int CNT_W = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;

  // Control registers
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [11:0] month_mask_r, month_mask_nxt;
  logic [30:0] day_mask_r, day_mask_nxt;
  logic [6:0]  weekday_mask_r, weekday_mask_nxt;
  logic [23:0] hour_mask_r, hour_mask_nxt;
  logic [59:0] minute_mask_r, minute_mask_nxt;
  logic [59:0] second_mask_r, second_mask_nxt;

  // Working registers
  logic [14:0]      y_r, y_nxt;
  logic [3:0]       mo_r, mo_nxt;
  logic [4:0]       d_r, d_nxt;
  logic [4:0]       h_r, h_nxt;
  logic [5:0]       mi_r, mi_nxt;
  logic [5:0]       s_r, s_nxt;
  logic [2:0]       wd_r, wd_nxt;
  logic [6:0]       c100_r, c100_nxt;
  logic [1:0]       c4h_r, c4h_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic [14:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  out_payload_t     out_data_r, out_data_nxt;

  // Shared multiplier operands
  logic [15:0] mul_a, mul_k;

  // Step datapath signals
  logic        leap;
  logic [4:0]  mlen;
  logic        day_ok;
  logic        month_adv, next_day, year_inc, hit, overflow;
  logic        run_end;
  logic [14:0] st_y;
  logic [3:0]  st_mo;
  logic [4:0]  st_d, st_h;
  logic [5:0]  st_mi, st_s;
  logic [2:0]  st_wd;
  logic [6:0]  st_c100;
  logic [1:0]  st_c4h;

  // Setup datapath signals
  logic [15:0] yy;
  logic [7:0]  q100;
  logic [12:0] q7;
  logic [4:0]  d_sat;
  logic [15:0] sum_full;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  assign leap = is_leap(y_r[1:0], c100_r, c4h_r);
  assign mlen = month_len(mo_r, leap);
  assign yy   = 16'(y_r) + 16'd400 - ((mo_r < 4'd3) ? 16'd1 : 16'd0);
  assign q100 = prod_r[28:21];
  assign q7   = prod_r[30:18];

  // Configuration writes
  always_comb begin
    month_mask_nxt   = month_mask_r;
    day_mask_nxt     = day_mask_r;
    weekday_mask_nxt = weekday_mask_r;
    hour_mask_nxt    = hour_mask_r;
    minute_mask_nxt  = minute_mask_r;
    second_mask_nxt  = second_mask_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MONTH:   month_mask_nxt   = cfg_wdata[11:0];
        CFG_DAY:     day_mask_nxt     = cfg_wdata[30:0];
        CFG_WEEKDAY: weekday_mask_nxt = cfg_wdata[6:0];
        CFG_HOUR:    hour_mask_nxt    = cfg_wdata[23:0];
        CFG_MINUTE:  minute_mask_nxt  = cfg_wdata[59:0];
        CFG_SECOND:  second_mask_nxt  = cfg_wdata[59:0];
        default: ;
      endcase
    end
  end

  // One search step
  always_comb begin
    st_y      = y_r;
    st_mo     = mo_r;
    st_d      = d_r;
    st_h      = h_r;
    st_mi     = mi_r;
    st_s      = s_r;
    st_wd     = wd_r;
    st_c100   = c100_r;
    st_c4h    = c4h_r;
    month_adv = 1'b0;
    next_day  = 1'b0;
    year_inc  = 1'b0;
    hit       = 1'b0;

    if (day_mask_r != DAY_ALL) begin
      day_ok = day_mask_r[d_r - 5'd1];
    end else begin
      day_ok = weekday_mask_r[wd_r];
    end

    priority if (!month_mask_r[mo_r - 4'd1]) begin
      // jump to the first of the next month
      month_adv = 1'b1;
      st_d      = 5'd1;
      st_h      = 5'd0;
      st_mi     = 6'd0;
      st_s      = 6'd0;
      st_wd     = mod7_small(6'(wd_r) + 6'(mlen) - 6'(d_r) + 6'd1);
    end else if (!day_ok) begin
      next_day = 1'b1;
    end else if (!hour_mask_r[h_r]) begin
      st_mi = 6'd0;
      st_s  = 6'd0;
      if (h_r == 5'd23) next_day = 1'b1;
      else              st_h = h_r + 5'd1;
    end else if (!minute_mask_r[mi_r]) begin
      st_s = 6'd0;
      if (mi_r == 6'd59) begin
        st_mi = 6'd0;
        if (h_r == 5'd23) next_day = 1'b1;
        else              st_h = h_r + 5'd1;
      end else begin
        st_mi = mi_r + 6'd1;
      end
    end else if (!second_mask_r[s_r]) begin
      if (s_r == 6'd59) begin
        st_s = 6'd0;
        if (mi_r == 6'd59) begin
          st_mi = 6'd0;
          if (h_r == 5'd23) next_day = 1'b1;
          else              st_h = h_r + 5'd1;
        end else begin
          st_mi = mi_r + 6'd1;
        end
      end else begin
        st_s = s_r + 6'd1;
      end
    end else begin
      hit = 1'b1;
    end

    // advance to the next midnight
    if (next_day) begin
      st_h  = 5'd0;
      st_mi = 6'd0;
      st_s  = 6'd0;
      st_wd = (wd_r == 3'd6) ? 3'd0 : wd_r + 3'd1;
      if (d_r >= mlen) begin
        st_d      = 5'd1;
        month_adv = 1'b1;
      end else begin
        st_d = d_r + 5'd1;
      end
    end

    if (month_adv) begin
      if (mo_r == 4'd12) begin
        st_mo    = 4'd1;
        year_inc = 1'b1;
      end else begin
        st_mo = mo_r + 4'd1;
      end
    end

    // carry the leap counters along with the year
    if (year_inc) begin
      st_y = y_r + 15'd1;
      if (c100_r == 7'd99) begin
        st_c100 = 7'd0;
        st_c4h  = c4h_r + 2'd1;
      end else begin
        st_c100 = c100_r + 7'd1;
      end
    end

    overflow = year_inc && (y_r == YEAR_LIMIT);
    run_end  = (cnt_r == '0) || hit || overflow;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_QY;
      S_QY:    state_nxt = S_QYY;
      S_QYY:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_Q7;
      S_Q7:    state_nxt = S_WD;
      S_WD:    state_nxt = S_RUN;
      S_RUN:   if (run_end) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    y_nxt         = y_r;
    mo_nxt        = mo_r;
    d_nxt         = d_r;
    h_nxt         = h_r;
    mi_nxt        = mi_r;
    s_nxt         = s_r;
    wd_nxt        = wd_r;
    c100_nxt      = c100_r;
    c4h_nxt       = c4h_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mul_a         = 16'd0;
    mul_k         = 16'd0;
    d_sat         = (d_r > mlen) ? mlen : d_r;
    sum_full      = yy + (yy >> 2) - 16'(q100) + 16'(q100 >> 2)
                    + 16'(wk_offset(mo_r)) + 16'(d_sat);

    unique case (state_r)
      S_IDLE: begin
        // load the start time, clamped into range
        if (in_ch.valid) begin
          y_nxt  = 15'(in_ch.payload.start_year);
          mo_nxt = (in_ch.payload.start_month == 4'd0) ? 4'd1 :
                   (in_ch.payload.start_month > 4'd12) ? 4'd12 : in_ch.payload.start_month;
          d_nxt  = (in_ch.payload.start_day == 5'd0) ? 5'd1 : in_ch.payload.start_day;
          h_nxt  = (in_ch.payload.start_hour > 5'd23) ? 5'd23 : in_ch.payload.start_hour;
          mi_nxt = (in_ch.payload.start_minute > 6'd59) ? 6'd59 : in_ch.payload.start_minute;
          s_nxt  = (in_ch.payload.start_second > 6'd59) ? 6'd59 : in_ch.payload.start_second;
        end
      end
      S_QY: begin
        mul_a = 16'(y_r);
        mul_k = K100;
      end
      S_QYY: begin
        c100_nxt = 7'(y_r - 15'(q100) * 15'd100);
        c4h_nxt  = q100[1:0];
        mul_a    = yy;
        mul_k    = K100;
      end
      S_SUM: begin
        d_nxt   = d_sat;
        sum_nxt = sum_full[14:0];
      end
      S_Q7: begin
        mul_a = 16'(sum_r);
        mul_k = K7;
      end
      S_WD: begin
        wd_nxt    = 3'(sum_r - 15'(q7) * 15'd7);
        cnt_nxt   = CNT_W'(MAX_STEPS - 1);
        found_nxt = 1'b0;
      end
      S_RUN: begin
        if (cnt_r == '0) begin
          found_nxt = 1'b0;
        end else if (hit) begin
          found_nxt = 1'b1;
        end else begin
          y_nxt     = st_y;
          mo_nxt    = st_mo;
          d_nxt     = st_d;
          h_nxt     = st_h;
          mi_nxt    = st_mi;
          s_nxt     = st_s;
          wd_nxt    = st_wd;
          c100_nxt  = st_c100;
          c4h_nxt   = st_c4h;
          cnt_nxt   = cnt_r - CNT_W'(1);
          found_nxt = 1'b0;
        end
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_data_nxt.found        = 1'b1;
            out_data_nxt.match_year   = y_r[13:0];
            out_data_nxt.match_month  = mo_r;
            out_data_nxt.match_day    = d_r;
            out_data_nxt.match_hour   = h_r;
            out_data_nxt.match_minute = mi_r;
            out_data_nxt.match_second = s_r;
          end else begin
            out_data_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_k;

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      month_mask_r   <= MONTH_ALL;
      day_mask_r     <= DAY_ALL;
      weekday_mask_r <= WEEKDAY_ALL;
      hour_mask_r    <= HOUR_ALL;
      minute_mask_r  <= MINSEC_ALL;
      second_mask_r  <= MINSEC_ALL;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      month_mask_r   <= month_mask_nxt;
      day_mask_r     <= day_mask_nxt;
      weekday_mask_r <= weekday_mask_nxt;
      hour_mask_r    <= hour_mask_nxt;
      minute_mask_r  <= minute_mask_nxt;
      second_mask_r  <= second_mask_nxt;
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    y_r        <= y_nxt;
    mo_r       <= mo_nxt;
    d_r        <= d_nxt;
    h_r        <= h_nxt;
    mi_r       <= mi_nxt;
    s_r        <= s_nxt;
    wd_r       <= wd_nxt;
    c100_r     <= c100_nxt;
    c4h_r      <= c4h_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
